FILE: sv/lfst_pkg.sv
package lfst_pkg;

  // Field widths
  localparam int FUNC_W      = 3;
  localparam int TAG_W       = 64;
  localparam int SLOT_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int TDATA_W     = 136;
  localparam int TUSER_IN_W  = FUNC_W;
  localparam int TUSER_OUT_W = STATUS_W;

  // Table sizing
  localparam int SLOTS_DEF   = 32;
  localparam int MAX_RESULTS = 32;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CFG_W     = 6;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(32);
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_PARK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LEAVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LIST  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MATCH = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  // Request from the sequencer to the tag store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [TAG_W-1:0]  wkey;
    logic [TAG_W-1:0]  wcol;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: sv/lowest_free_slot_tag_table_top.sv
// Channel   Dir  Handshake                    Contents
// s_*       in   s_tvalid / s_tready          command: func, key, colour, slot
// m_*       out  m_tvalid / m_tready          result: status, slot, key, colour, last
// APB       in   psel & penable & pwrite      slots_in_use at byte address 0
//
// One command walks the slots in service one per cycle through the tag store's
// single read port, unless the result output stalls; leave and read slot touch
// one slot, and a find that hits early or a park that finds a free slot stops early.
// Reset frees every slot and sets slots_in_use to 32; no clearing pass.
// A stalled result output holds the walk; s_tready is low while a command runs.
module lowest_free_slot_tag_table_top #(
  parameter int SLOTS = lfst_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lfst_pkg::TDATA_W-1:0]     s_tdata,  // key_tag, colour_tag, slot_in, pad
  input  logic [lfst_pkg::TUSER_IN_W-1:0]  s_tuser,  // func
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lfst_pkg::TDATA_W-1:0]     m_tdata,  // slot_out, key_out, colour_out, pad
  output logic [lfst_pkg::TUSER_OUT_W-1:0] m_tuser,  // status
  output logic                             m_tlast,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfst_pkg::PADDR_W-1:0]     paddr,
  input  logic [lfst_pkg::PDATA_W-1:0]     pwdata,
  output logic [lfst_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int TW = lfst_pkg::TAG_W;
  localparam int SW = lfst_pkg::SLOT_W;

  logic [lfst_pkg::CFG_W-1:0] slots_in_use;
  logic                       reg_sel;

  logic [SW-1:0] slot_out;
  logic [TW-1:0] key_out;
  logic [TW-1:0] colour_out;

  lfst_pkg::mem_req_t mem_req;
  logic [TW-1:0]      rd_key;
  logic [TW-1:0]      rd_col;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lfst_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= lfst_pkg::SLOTS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      slots_in_use <= pwdata[lfst_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(lfst_pkg::PDATA_W - lfst_pkg::CFG_W){1'b0}}, slots_in_use}
                          : '0;

  // sequencer and shared compare
  lfst_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .slots_in_use(slots_in_use),
    .cmd_valid   (s_tvalid),
    .cmd_ready   (s_tready),
    .func        (s_tuser),
    .key_tag     (s_tdata[TW-1:0]),
    .colour_tag  (s_tdata[2*TW-1:TW]),
    .slot_in     (s_tdata[2*TW+SW-1:2*TW]),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .status      (m_tuser),
    .slot_out    (slot_out),
    .key_out     (key_out),
    .colour_out  (colour_out),
    .last        (m_tlast),
    .mem_req     (mem_req),
    .rd_key      (rd_key),
    .rd_col      (rd_col)
  );

  // key and colour memory
  lfst_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk   (clk),
    .req   (mem_req),
    .rd_key(rd_key),
    .rd_col(rd_col)
  );

  assign m_tdata = {{(lfst_pkg::TDATA_W - 2*TW - SW){1'b0}}, colour_out, key_out, slot_out};

endmodule

FILE: sv/lfst_store.sv
module lfst_store #(
  parameter int SLOTS = lfst_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  lfst_pkg::mem_req_t        req,
  output logic [lfst_pkg::TAG_W-1:0] rd_key,
  output logic [lfst_pkg::TAG_W-1:0] rd_col
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [lfst_pkg::TAG_W-1:0] key_mem [SLOTS];
  logic [lfst_pkg::TAG_W-1:0] col_mem [SLOTS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.waddr[IW-1:0]] <= req.wkey;
      col_mem[req.waddr[IW-1:0]] <= req.wcol;
    end
    if (req.re) begin
      rd_key <= key_mem[req.raddr[IW-1:0]];
      rd_col <= col_mem[req.raddr[IW-1:0]];
    end
  end

endmodule

FILE: sv/lfst_seq.sv
module lfst_seq #(
  parameter int SLOTS = lfst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lfst_pkg::CFG_W-1:0]    slots_in_use,
  // command side
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [lfst_pkg::FUNC_W-1:0]   func,
  input  logic [lfst_pkg::TAG_W-1:0]    key_tag,
  input  logic [lfst_pkg::TAG_W-1:0]    colour_tag,
  input  logic [lfst_pkg::SLOT_W-1:0]   slot_in,
  // result side
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [lfst_pkg::STATUS_W-1:0] status,
  output logic [lfst_pkg::SLOT_W-1:0]   slot_out,
  output logic [lfst_pkg::TAG_W-1:0]    key_out,
  output logic [lfst_pkg::TAG_W-1:0]    colour_out,
  output logic                          last,
  // tag store
  output lfst_pkg::mem_req_t            mem_req,
  input  logic [lfst_pkg::TAG_W-1:0]    rd_key,
  input  logic [lfst_pkg::TAG_W-1:0]    rd_col
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW = lfst_pkg::SLOT_W;
  localparam int TW = lfst_pkg::TAG_W;

  lfst_pkg::state_t state;

  // latched command
  logic [lfst_pkg::FUNC_W-1:0] op;
  logic [TW-1:0]               op_key;
  logic [TW-1:0]               op_col;
  logic [SW-1:0]               op_slot;
  logic                        oor;

  // walk pointers: a = address issued, b = data returned
  logic [SW-1:0] a_idx;
  logic [SW-1:0] end_idx;
  logic          b_vld;
  logic [SW-1:0] b_idx;
  logic          stop;

  // held scan match, emitted once the next one shows whether it is last
  logic          pend_vld;
  logic [SW-1:0] pend_slot;
  logic [TW-1:0] pend_key;
  logic [TW-1:0] pend_col;
  logic [SW-1:0] res_cnt;

  logic [SLOTS-1:0] occ;

  logic [SW-1:0] n_svc;
  logic          start_oor;
  logic [SW-1:0] start_a;
  logic [SW-1:0] start_end;
  logic          is_scan;
  logic          a_more;
  logic          occ_b;
  logic [TW-1:0] cmp_a;
  logic [TW-1:0] cmp_b;
  logic          tag_eq;
  logic          hit;
  logic          free;
  logic          need_out;
  logic          adv;
  logic          walk_end;
  logic          cap;
  logic          cap_last;
  logic          done;
  logic          emit;
  logic [lfst_pkg::STATUS_W-1:0] e_status;
  logic [SW-1:0] e_slot;
  logic [TW-1:0] e_key;
  logic [TW-1:0] e_col;
  logic          e_last;
  logic          accept;

  // slots in service, capped at the table size
  assign n_svc = ({1'b0, slots_in_use} > 7'(SLOTS)) ? SW'(SLOTS) : slots_in_use;

  assign cmd_ready = (state == lfst_pkg::S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // walk range for a new command; leave and read slot touch one slot
  always_comb begin
    start_oor = 1'b0;
    start_a   = '0;
    start_end = n_svc;
    if ((func == lfst_pkg::FN_LEAVE) || (func == lfst_pkg::FN_READ)) begin
      if ((slot_in == '0) || (slot_in > n_svc)) begin
        start_oor = 1'b1;
        start_end = '0;
      end else begin
        start_a   = slot_in - SW'(1);
        start_end = slot_in;
      end
    end
  end

  assign is_scan  = (op == lfst_pkg::FN_LIST) || (op == lfst_pkg::FN_MATCH);
  assign a_more   = (a_idx < end_idx) && !stop;
  assign occ_b    = occ[b_idx[IW-1:0]];
  assign walk_end = !b_vld && !a_more;

  // shared tag comparator
  assign cmp_a  = (op == lfst_pkg::FN_MATCH) ? rd_col : rd_key;
  assign cmp_b  = (op == lfst_pkg::FN_MATCH) ? op_col : op_key;
  assign tag_eq = (cmp_a == cmp_b);

  always_comb begin
    unique case (op)
      lfst_pkg::FN_PARK:                    hit = !occ_b;
      lfst_pkg::FN_LEAVE, lfst_pkg::FN_READ: hit = occ_b;
      lfst_pkg::FN_LIST:                    hit = occ_b;
      lfst_pkg::FN_MATCH, lfst_pkg::FN_FIND: hit = occ_b && tag_eq;
      default:                              hit = 1'b0;
    endcase
  end

  assign free     = !res_valid || res_ready;
  assign need_out = b_vld && hit && (!is_scan || pend_vld);
  assign adv      = !need_out || free;
  assign cap_last = cap && (res_cnt == SW'(lfst_pkg::MAX_RESULTS - 1));

  // result selection for the current cycle
  always_comb begin
    emit     = 1'b0;
    done     = 1'b0;
    cap      = 1'b0;
    e_status = lfst_pkg::ST_OK;
    e_slot   = '0;
    e_key    = '0;
    e_col    = '0;
    e_last   = 1'b1;
    if (state == lfst_pkg::S_WALK) begin
      if (b_vld && hit) begin
        if (!is_scan) begin
          if (free) begin
            emit   = 1'b1;
            done   = 1'b1;
            e_slot = b_idx + SW'(1);
            e_key  = (op == lfst_pkg::FN_PARK) ? op_key : rd_key;
            e_col  = (op == lfst_pkg::FN_PARK) ? op_col : rd_col;
          end
        end else if (pend_vld) begin
          if (free) begin
            emit   = 1'b1;
            cap    = 1'b1;
            e_slot = pend_slot;
            e_key  = pend_key;
            e_col  = pend_col;
            e_last = 1'b0;
          end
        end else begin
          cap = 1'b1;
        end
      end else if (walk_end && free) begin
        emit = 1'b1;
        done = 1'b1;
        case (op)
          lfst_pkg::FN_PARK: e_status = lfst_pkg::ST_FULL;
          lfst_pkg::FN_LEAVE, lfst_pkg::FN_READ: begin
            e_status = oor ? lfst_pkg::ST_RANGE : lfst_pkg::ST_EMPTY;
            e_slot   = oor ? '0 : op_slot;
          end
          lfst_pkg::FN_LIST, lfst_pkg::FN_MATCH: begin
            if (pend_vld) begin
              e_slot = pend_slot;
              e_key  = pend_key;
              e_col  = pend_col;
            end else begin
              e_status = lfst_pkg::ST_EMPTY;
            end
          end
          default: e_status = lfst_pkg::ST_EMPTY;
        endcase
      end
    end
  end

  // tag store access
  always_comb begin
    mem_req.we    = (state == lfst_pkg::S_WALK) && b_vld && hit && free &&
                    (op == lfst_pkg::FN_PARK);
    mem_req.waddr = b_idx;
    mem_req.wkey  = op_key;
    mem_req.wcol  = op_col;
    mem_req.re    = (state == lfst_pkg::S_WALK) && adv && a_more;
    mem_req.raddr = a_idx;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lfst_pkg::S_IDLE;
      b_vld    <= 1'b0;
      stop     <= 1'b0;
      pend_vld <= 1'b0;
      res_cnt  <= '0;
      occ      <= '0;
    end else begin
      unique case (state)
        lfst_pkg::S_IDLE: begin
          if (accept) begin
            b_vld    <= 1'b0;
            stop     <= 1'b0;
            pend_vld <= 1'b0;
            res_cnt  <= '0;
            unique case (func)
              lfst_pkg::FN_PARK, lfst_pkg::FN_LIST, lfst_pkg::FN_MATCH,
              lfst_pkg::FN_FIND, lfst_pkg::FN_LEAVE, lfst_pkg::FN_READ:
                state <= lfst_pkg::S_WALK;
              default: state <= lfst_pkg::S_IDLE;
            endcase
          end
        end
        lfst_pkg::S_WALK: begin
          if (cap) begin
            pend_vld <= 1'b1;
            res_cnt  <= res_cnt + SW'(1);
          end
          if (cap_last) begin
            stop <= 1'b1;
          end
          if (mem_req.we) begin
            occ[b_idx[IW-1:0]] <= 1'b1;
          end
          if (emit && done && (op == lfst_pkg::FN_LEAVE) && b_vld && hit) begin
            occ[b_idx[IW-1:0]] <= 1'b0;
          end
          if (done) begin
            state <= lfst_pkg::S_IDLE;
            b_vld <= 1'b0;
          end else if (adv) begin
            b_vld <= a_more && !cap_last;
          end
        end
        default: state <= lfst_pkg::S_IDLE;
      endcase
    end
  end

  // command latch and walk pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= func;
      op_key  <= key_tag;
      op_col  <= colour_tag;
      op_slot <= slot_in;
      oor     <= start_oor;
      a_idx   <= start_a;
      end_idx <= start_end;
    end else if ((state == lfst_pkg::S_WALK) && adv) begin
      b_idx <= a_idx;
      if (a_more) begin
        a_idx <= a_idx + SW'(1);
      end
    end
  end

  // held scan match
  always_ff @(posedge clk) begin
    if (cap) begin
      pend_slot <= b_idx + SW'(1);
      pend_key  <= rd_key;
      pend_col  <= rd_col;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status     <= e_status;
      slot_out   <= e_slot;
      key_out    <= e_key;
      colour_out <= e_col;
      last       <= e_last;
    end
  end

endmodule

FILE: sv/lfst_checker.sv
module lfst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [lfst_pkg::TUSER_IN_W-1:0]  s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lfst_pkg::TDATA_W-1:0]     m_tdata,
  input logic [lfst_pkg::TUSER_OUT_W-1:0] m_tuser,
  input logic                             m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // an accepted known command makes the block busy in the cycle after
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser <= lfst_pkg::FN_READ) |=> !s_tready)
    else $error("command accepted back to back");

  // full and out-of-range results name no slot
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == lfst_pkg::ST_FULL) || (m_tuser == lfst_pkg::ST_RANGE))
    |-> (m_tdata[lfst_pkg::SLOT_W-1:0] == '0))
    else $error("slot reported with full or out-of-range status");

  // any failing status is the only and last result of its command
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lfst_pkg::ST_OK) |-> m_tlast)
    else $error("error result without last");

endmodule

bind lowest_free_slot_tag_table_top lfst_checker u_chk (.*);
